/* rtl/nested_length_prefixed_deframer_macros.svh */
// Assertion macros for the nested length-prefixed deframer.
`ifndef NESTED_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define NESTED_LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

`ifndef SYNTH
`define NLPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Deframer assertion failed.");
`define NLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Deframer assertion failed.");
`else
`define NLPD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define NLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/nlpd_pkg.sv */
// Types and constants of the nested length-prefixed deframer.
package nlpd_pkg;

    localparam int MAX_STRINGS_DEF    = 1024;
    localparam int FRAME_BUFFER_BYTES = 7000;
    localparam int FRAME_HEADER_BYTES = 5;
    localparam logic [31:0] MAX_BODY_RESET = 32'(FRAME_BUFFER_BYTES - FRAME_HEADER_BYTES);

    localparam logic [1:0] ROLE_TYPE    = 2'd0;
    localparam logic [1:0] ROLE_BODYLEN = 2'd1;
    localparam logic [1:0] ROLE_STRLEN  = 2'd2;
    localparam logic [1:0] ROLE_DATA    = 2'd3;

    localparam logic [1:0] LAST_LEN_BYTE = 2'd3;

    typedef enum logic [3:0] {
        PH_TYPE    = 4'b0001,
        PH_BODYLEN = 4'b0010,
        PH_STRLEN  = 4'b0100,
        PH_DATA    = 4'b1000
    } t_phase;

endpackage

/* rtl/nested_length_prefixed_deframer.sv */
// Each result is registered at the edge that accepts its byte.
// Throughput: one byte per cycle unless stalled; the parser state and result
// register update at the accepting edge, so the next byte may follow at once.
// Reset clears the parser to expect a type byte, empties the result register
// and loads the body length limit with 6995.
// Top level of the nested length-prefixed deframer.
`include "nested_length_prefixed_deframer_macros.svh"

module nested_length_prefixed_deframer
    import nlpd_pkg::*;
#(
    parameter int MAX_STRINGS = MAX_STRINGS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_byte_role,
    output logic [7:0]  o_frame_type,
    output logic [9:0]  o_string_index,
    output logic [7:0]  o_byte_value,
    output logic        o_string_end,
    output logic        o_frame_end,
    output logic        o_frame_error,
    output logic [10:0] o_string_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_STRINGS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STRINGS);

    t_phase           r_phase, n_phase;
    logic [1:0]       r_hdr_cnt, n_hdr_cnt;
    logic [31:0]      r_body_rem, n_body_rem;
    logic [31:0]      r_str_rem, n_str_rem;
    logic [CNT_W-1:0] r_cur_str, n_cur_str;
    logic [7:0]       r_cur_type, n_cur_type;
    logic             r_err_seen, n_err_seen;
    logic [31:0]      r_max_body;

    logic             r_out_valid;
    logic [1:0]       r_byte_role, n_byte_role;
    logic [7:0]       r_frame_type;
    logic [9:0]       r_string_index, n_string_index;
    logic [7:0]       r_byte_value;
    logic             r_string_end, n_string_end;
    logic             r_frame_end, n_frame_end;
    logic             r_frame_error;
    logic [10:0]      r_string_count, n_string_count;

    logic             in_accept;
    logic [31:0]      body_shift, str_shift, body_dec, str_dec, idx_ext, cnt_ext;
    logic [CNT_W-1:0] cur_fin;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign body_shift = {r_body_rem[23:0], i_data_byte};
    assign str_shift  = {r_str_rem[23:0], i_data_byte};
    assign body_dec   = r_body_rem - 32'd1;
    assign str_dec    = r_str_rem - 32'd1;
    assign cur_fin    = (r_cur_str < CNT_MAX) ? r_cur_str + CNT_W'(1) : r_cur_str;
    assign idx_ext    = (r_cur_str >= CNT_MAX) ? 32'(MAX_STRINGS - 1) : 32'(r_cur_str);
    assign cnt_ext    = 32'(n_cur_str);

    always_comb begin
        n_phase        = r_phase;
        n_hdr_cnt      = r_hdr_cnt;
        n_body_rem     = r_body_rem;
        n_str_rem      = r_str_rem;
        n_cur_str      = r_cur_str;
        n_cur_type     = r_cur_type;
        n_err_seen     = r_err_seen;
        n_byte_role    = ROLE_TYPE;
        n_string_index = 10'd0;
        n_string_end   = 1'b0;
        n_frame_end    = 1'b0;
        case (r_phase)
            PH_TYPE: begin
                n_byte_role = ROLE_TYPE;
                n_cur_type  = i_data_byte;
                n_cur_str   = '0;
                n_err_seen  = 1'b0;
                n_hdr_cnt   = 2'd0;
                n_body_rem  = 32'd0;
                n_phase     = PH_BODYLEN;
            end
            PH_BODYLEN: begin
                n_byte_role = ROLE_BODYLEN;
                n_body_rem  = body_shift;
                if (r_hdr_cnt == LAST_LEN_BYTE) begin
                    n_hdr_cnt = 2'd0;
                    if (body_shift > r_max_body) begin
                        n_err_seen = 1'b1;
                    end
                    if (body_shift == 32'd0) begin
                        n_frame_end = 1'b1;
                        n_phase     = PH_TYPE;
                    end else begin
                        n_str_rem = 32'd0;
                        n_phase   = PH_STRLEN;
                    end
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 2'd1;
                end
            end
            PH_STRLEN: begin
                n_byte_role    = ROLE_STRLEN;
                n_string_index = idx_ext[9:0];
                n_body_rem     = body_dec;
                n_str_rem      = str_shift;
                if (r_hdr_cnt == 2'd0 && r_cur_str >= CNT_MAX) begin
                    n_err_seen = 1'b1;
                end
                if (r_hdr_cnt == LAST_LEN_BYTE) begin
                    n_hdr_cnt = 2'd0;
                    if (str_shift > body_dec) begin
                        n_err_seen = 1'b1;
                        n_str_rem  = body_dec;
                    end
                    if (n_str_rem == 32'd0) begin
                        n_string_end = 1'b1;
                        n_cur_str    = cur_fin;
                        if (body_dec == 32'd0) begin
                            n_frame_end = 1'b1;
                            n_phase     = PH_TYPE;
                        end
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 2'd1;
                    if (body_dec == 32'd0) begin
                        n_err_seen  = 1'b1;
                        n_frame_end = 1'b1;
                        n_hdr_cnt   = 2'd0;
                        n_phase     = PH_TYPE;
                    end
                end
            end
            PH_DATA: begin
                n_byte_role    = ROLE_DATA;
                n_string_index = idx_ext[9:0];
                n_body_rem     = body_dec;
                n_str_rem      = str_dec;
                if (str_dec == 32'd0) begin
                    n_string_end = 1'b1;
                    n_cur_str    = cur_fin;
                    if (body_dec == 32'd0) begin
                        n_frame_end = 1'b1;
                        n_phase     = PH_TYPE;
                    end else begin
                        n_phase = PH_STRLEN;
                    end
                end
            end
            default: begin
                n_phase = PH_TYPE;
            end
        endcase
        n_string_count = (n_byte_role == ROLE_STRLEN || n_byte_role == ROLE_DATA)
                         ? cnt_ext[10:0] : 11'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TYPE;
            r_hdr_cnt   <= 2'd0;
            r_body_rem  <= 32'd0;
            r_str_rem   <= 32'd0;
            r_cur_str   <= '0;
            r_cur_type  <= 8'd0;
            r_err_seen  <= 1'b0;
            r_max_body  <= MAX_BODY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_body <= i_cfg_data;
            end
            if (in_accept) begin
                r_phase     <= n_phase;
                r_hdr_cnt   <= n_hdr_cnt;
                r_body_rem  <= n_body_rem;
                r_str_rem   <= n_str_rem;
                r_cur_str   <= n_cur_str;
                r_cur_type  <= n_cur_type;
                r_err_seen  <= n_err_seen;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byte_role    <= n_byte_role;
            r_frame_type   <= n_cur_type;
            r_string_index <= n_string_index;
            r_byte_value   <= i_data_byte;
            r_string_end   <= n_string_end;
            r_frame_end    <= n_frame_end;
            r_frame_error  <= n_frame_end && n_err_seen;
            r_string_count <= n_string_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_role    = r_byte_role;
    assign o_frame_type   = r_frame_type;
    assign o_string_index = r_string_index;
    assign o_byte_value   = r_byte_value;
    assign o_string_end   = r_string_end;
    assign o_frame_end    = r_frame_end;
    assign o_frame_error  = r_frame_error;
    assign o_string_count = r_string_count;

    `NLPD_ASSERT_NOW(a_error_at_end, i_clk, i_rst_n, o_out_valid && o_frame_error, o_frame_end)
    `NLPD_ASSERT_NOW(a_end_to_type, i_clk, i_rst_n, o_out_valid && o_frame_end, r_phase == PH_TYPE)
    `NLPD_ASSERT_NOW(a_str_end_phase, i_clk, i_rst_n, o_out_valid && o_string_end,
                     r_phase == PH_STRLEN || r_phase == PH_TYPE)
    `NLPD_ASSERT_NEXT(a_accept_shows, i_clk, i_rst_n, in_accept, o_out_valid)

endmodule
